### sv/sha256t_pkg.sv
// ----------------------------------------------------------------------------
// sha256t_pkg
// shared constants and round functions for the truncated sha-256 hasher
// ----------------------------------------------------------------------------
package sha256t_pkg;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef logic [31:0] t_word;

    function automatic t_word f_iv(input logic [2:0] idx);
        t_word w;
        case (idx)
            3'd0:    w = 32'h6a09e667;
            3'd1:    w = 32'hbb67ae85;
            3'd2:    w = 32'h3c6ef372;
            3'd3:    w = 32'ha54ff53a;
            3'd4:    w = 32'h510e527f;
            3'd5:    w = 32'h9b05688c;
            3'd6:    w = 32'h1f83d9ab;
            3'd7:    w = 32'h5be0cd19;
            default: w = 32'h0;
        endcase
        return w;
    endfunction

    function automatic t_word f_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0: k=32'h428a2f98; 6'd1: k=32'h71374491; 6'd2: k=32'hb5c0fbcf;
            6'd3: k=32'he9b5dba5; 6'd4: k=32'h3956c25b; 6'd5: k=32'h59f111f1;
            6'd6: k=32'h923f82a4; 6'd7: k=32'hab1c5ed5; 6'd8: k=32'hd807aa98;
            6'd9: k=32'h12835b01; 6'd10: k=32'h243185be; 6'd11: k=32'h550c7dc3;
            6'd12: k=32'h72be5d74; 6'd13: k=32'h80deb1fe; 6'd14: k=32'h9bdc06a7;
            6'd15: k=32'hc19bf174; 6'd16: k=32'he49b69c1; 6'd17: k=32'hefbe4786;
            6'd18: k=32'h0fc19dc6; 6'd19: k=32'h240ca1cc; 6'd20: k=32'h2de92c6f;
            6'd21: k=32'h4a7484aa; 6'd22: k=32'h5cb0a9dc; 6'd23: k=32'h76f988da;
            6'd24: k=32'h983e5152; 6'd25: k=32'ha831c66d; 6'd26: k=32'hb00327c8;
            6'd27: k=32'hbf597fc7; 6'd28: k=32'hc6e00bf3; 6'd29: k=32'hd5a79147;
            6'd30: k=32'h06ca6351; 6'd31: k=32'h14292967; 6'd32: k=32'h27b70a85;
            6'd33: k=32'h2e1b2138; 6'd34: k=32'h4d2c6dfc; 6'd35: k=32'h53380d13;
            6'd36: k=32'h650a7354; 6'd37: k=32'h766a0abb; 6'd38: k=32'h81c2c92e;
            6'd39: k=32'h92722c85; 6'd40: k=32'ha2bfe8a1; 6'd41: k=32'ha81a664b;
            6'd42: k=32'hc24b8b70; 6'd43: k=32'hc76c51a3; 6'd44: k=32'hd192e819;
            6'd45: k=32'hd6990624; 6'd46: k=32'hf40e3585; 6'd47: k=32'h106aa070;
            6'd48: k=32'h19a4c116; 6'd49: k=32'h1e376c08; 6'd50: k=32'h2748774c;
            6'd51: k=32'h34b0bcb5; 6'd52: k=32'h391c0cb3; 6'd53: k=32'h4ed8aa4a;
            6'd54: k=32'h5b9cca4f; 6'd55: k=32'h682e6ff3; 6'd56: k=32'h748f82ee;
            6'd57: k=32'h78a5636f; 6'd58: k=32'h84c87814; 6'd59: k=32'h8cc70208;
            6'd60: k=32'h90befffa; 6'd61: k=32'ha4506ceb; 6'd62: k=32'hbef9a3f7;
            6'd63: k=32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word f_rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word f_ssig0(input t_word x);
        return f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word f_ssig1(input t_word x);
        return f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word f_bsig0(input t_word x);
        return f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic t_word f_bsig1(input t_word x);
        return f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

endpackage

### sv/sha256t_core.sv
// ----------------------------------------------------------------------------
// sha256t_core
// compression unit: 64 rounds, one per cycle, message words streamed from the
// block memory for the first 16 rounds, then taken from a 16-word window
// ----------------------------------------------------------------------------
module sha256t_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  sha256t_pkg::t_word      i_word,
    input  sha256t_pkg::t_word      i_h [8],
    output logic [3:0]              o_raddr,
    output logic                    o_busy,
    output logic                    o_done,
    output sha256t_pkg::t_word      o_v [8]
);

    logic                r_busy;
    logic [5:0]          r_rnd;
    logic                r_done;
    sha256t_pkg::t_word  r_v [8];
    sha256t_pkg::t_word  r_w [16];   // the last sixteen schedule words
    sha256t_pkg::t_word  r_wn;       // schedule word for the next round
    sha256t_pkg::t_word  t1, t2, w_cur, w_next, maj, ch;

    always_comb begin
        // rounds 0..15 use the memory word, later rounds the computed one
        w_cur  = (r_rnd[5:4] == 2'b00) ? i_word : r_wn;
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + sha256t_pkg::f_bsig1(r_v[4]) + ch
                 + sha256t_pkg::f_k(r_rnd) + w_cur;
        t2     = sha256t_pkg::f_bsig0(r_v[0]) + maj;
        // one word ahead, from registers only
        w_next = r_w[1] + sha256t_pkg::f_ssig0(r_w[2]) + r_w[10]
                 + sha256t_pkg::f_ssig1(r_w[15]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            for (int i = 0; i < 8; i++) r_v[i] <= i_h[i];
        end else if (r_busy) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_cur;
            r_wn    <= w_next;
        end
    end

    // word 0 is read while idle, word t+1 during round t
    assign o_raddr = r_busy ? (r_rnd[3:0] + 4'd1) : 4'd0;
    assign o_busy  = r_busy;
    assign o_done  = r_done;
    always_comb for (int i = 0; i < 8; i++) o_v[i] = r_v[i];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && !r_busy) else $error("done without run");
    a_round_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_rnd == 6'd63 |=> !r_busy) else $error("round overrun");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(r_busy) |-> r_rnd == 6'd0) else $error("bad start");

endmodule

### sv/sha256_truncated_128_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_truncated_128_hasher_top
// streaming sha-256 with the first 128 digest bits as two 64-bit items
// ----------------------------------------------------------------------------
//  channel | signals                                  | moves
//  in      | i_valid, o_ready, i_command, i_data_byte | one byte or finish item
//  out     | o_valid, i_ready, o_digest_half, o_last  | one digest half item
//
//  absorb: one byte per cycle while the block is filling; the byte that fills the
//  block holds o_ready low through one memory read, 64 rounds and one update
//  finish: one padding byte per cycle up to the block end, then a compression;
//  when the 0x80 byte lands at offset 56 or later a second 64-byte pad block and
//  compression follow; then two output items, each held until taken
//  reset restores initial hash words, zero count and length; o_ready is high
//  only in idle
// ----------------------------------------------------------------------------
module sha256_truncated_128_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_half,
    output logic        o_last
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,   // push padding / length bytes
        ST_LOAD  = 6'b000100,   // block memory read settles
        ST_RUN   = 6'b001000,   // compression active
        ST_OUT0  = 6'b010000,
        ST_OUT1  = 6'b100000
    } t_state;

    t_state              r_state;
    logic [5:0]          r_fill;
    logic [63:0]         r_len;
    logic [63:0]         r_len_snap;
    logic                r_fin;      // finish in progress
    logic                r_pad_first;
    logic                r_len_blk;  // current pad block carries the length
    sha256t_pkg::t_word  r_h [8];
    // block store: 16 word rows of 32 bits, byte writes, one word read a cycle
    sha256t_pkg::t_word  r_mem [16];
    sha256t_pkg::t_word  r_rd;

    logic                push;
    logic [7:0]          push_byte;
    logic                core_start, core_busy, core_done;
    logic [3:0]          core_raddr;
    sha256t_pkg::t_word  core_v [8];
    logic                in_acc;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);

    // byte source: host data or padding sequence
    always_comb begin
        push      = 1'b0;
        push_byte = 8'h00;
        if (r_state == ST_IDLE && in_acc && i_command == sha256t_pkg::CMD_ABSORB) begin
            push      = 1'b1;
            push_byte = i_data_byte;
        end else if (r_state == ST_PAD) begin
            push = 1'b1;
            if (r_pad_first) push_byte = sha256t_pkg::PAD_BYTE;
            else if (r_len_blk && r_fill >= sha256t_pkg::LEN_POS)
                push_byte = r_len_snap[{~r_fill[2:0], 3'b000} +: 8];
            else push_byte = 8'h00;
        end
    end

    // block memory: big-endian bytes within a word; no writes while compressing
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= push_byte;
        r_rd <= r_mem[core_raddr];
    end

    assign core_start = (r_state == ST_LOAD);

    sha256t_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_word  (r_rd),
        .i_h     (r_h),
        .o_raddr (core_raddr),
        .o_busy  (core_busy),
        .o_done  (core_done),
        .o_v     (core_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_fin       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_blk   <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256t_pkg::f_iv(3'(i));
        end else begin
            if (push) r_fill <= r_fill + 6'd1;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_command == sha256t_pkg::CMD_ABSORB) begin
                            r_len <= r_len + 64'd8;
                            if (r_fill == 6'd63) r_state <= ST_LOAD;
                        end else begin
                            r_len_snap  <= r_len;
                            r_fin       <= 1'b1;
                            r_pad_first <= 1'b1;
                            // length fits after the 0x80 byte in this block
                            r_len_blk   <= (r_fill < sha256t_pkg::LEN_POS);
                            r_state     <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_first <= 1'b0;
                    if (r_fill == 6'd63) r_state <= ST_LOAD;
                end
                ST_LOAD: r_state <= ST_RUN;
                ST_RUN: begin
                    if (core_done) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + core_v[i];
                        if (!r_fin) r_state <= ST_IDLE;
                        else if (r_len_blk) r_state <= ST_OUT0;
                        else begin
                            // zero block done, length goes in the next one
                            r_len_blk <= 1'b1;
                            r_state   <= ST_PAD;
                        end
                    end
                end
                ST_OUT0: if (i_ready) r_state <= ST_OUT1;
                ST_OUT1: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                        r_fin   <= 1'b0;
                        r_len   <= '0;
                        for (int i = 0; i < 8; i++) r_h[i] <= sha256t_pkg::f_iv(3'(i));
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid       = (r_state == ST_OUT0) || (r_state == ST_OUT1);
    assign o_last        = (r_state == ST_OUT1);
    assign o_digest_half = o_last ? {r_h[2], r_h[3]} : {r_h[0], r_h[1]};

    a_out_only_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_fin) else $error("digest without finish");
    a_fill_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_fill == 6'd0) else $error("partial block at output");
    a_core_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |=> core_busy) else $error("core did not start");

endmodule

### bench/sha256t_checker.sv
// ----------------------------------------------------------------------------
// sha256t_checker
// watches both channels, predicts the truncated sha-256 digest, compares
// ----------------------------------------------------------------------------
module sha256t_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_valid_out,
    input  logic        i_ready_out,
    input  logic [63:0] i_digest_half,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] half;
        logic        last;
    } t_half;

    localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0] hw [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] nbits;
    t_half       digest_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = digest_q.size();

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, e, a;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        v = hw;
        for (int t = 0; t < 64; t++) begin
            e  = v[4];
            a  = v[0];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + KTAB[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            hw[t] += v[t];
    endtask

    task automatic push_byte(input logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 0)
            compress();
    endtask

    task automatic absorb_or_finish(input logic cmd, input logic [7:0] b);
        logic [63:0] len;
        if (cmd == sha256t_pkg::CMD_ABSORB) begin
            push_byte(b);
            nbits += 64'd8;
        end else begin
            len = nbits;
            push_byte(sha256t_pkg::PAD_BYTE);
            while (fill != sha256t_pkg::LEN_POS)
                push_byte(8'h00);
            for (int i = 7; i >= 0; i--)
                push_byte(len[8*i +: 8]);
            digest_q.push_back('{half: {hw[0], hw[1]}, last: 1'b0});
            digest_q.push_back('{half: {hw[2], hw[3]}, last: 1'b1});
            hw    = IV;
            fill  = '0;
            nbits = '0;
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fails++;
    endtask

    initial begin
        hw    = IV;
        fill  = '0;
        nbits = '0;
        fails = 0;
    end

    t_half exp_h;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && i_ready_in)
                absorb_or_finish(i_command, i_data_byte);
            if (i_valid_out && i_ready_out) begin
                if (digest_q.size() == 0) begin
                    report("unexpected item", i_digest_half, 64'd0);
                end else begin
                    exp_h = digest_q.pop_front();
                    if (i_digest_half !== exp_h.half)
                        report("digest_half", i_digest_half, exp_h.half);
                    if (i_last !== exp_h.last)
                        report("last", {63'd0, i_last}, {63'd0, exp_h.last});
                end
            end
        end
    end
endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives byte and finish items into the truncated sha-256 hasher under
// several idling phases; the checker predicts and compares every digest half
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = sha256t_pkg::CMD_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] digest_half;
    logic        last;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;   // chance of a gap before each item
    int          recv_stall_pct = 0;  // chance of ready low each cycle
    longint      cycles = 0;

    localparam longint CYCLE_LIMIT = 2_000_000;

    always #10 clk = ~clk;

    sha256_truncated_128_hasher_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_command     (cmd),
        .i_data_byte   (data_byte),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_digest_half (digest_half),
        .o_last        (last)
    );

    sha256t_checker i_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .i_ready_in    (in_ready),
        .i_command     (cmd),
        .i_data_byte   (data_byte),
        .i_valid_out   (out_valid),
        .i_ready_out   (out_ready),
        .i_digest_half (digest_half),
        .i_last        (last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // receiver stalls at random; one assignment per edge
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // send one item: optional idle gap, then hold valid until accepted;
    // valid stays high after the accepting edge only until the next call
    task automatic send_item(input logic c, input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // message of n random bytes then finish
    task automatic send_message(input int n);
        for (int i = 0; i < n; i++)
            send_item(sha256t_pkg::CMD_ABSORB, 8'($urandom));
        send_item(sha256t_pkg::CMD_FINISH, 8'($urandom));
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(9);
        if (r < 3)
            return $urandom_range(64) + 0;              // up to one block
        else if (r < 6)
            return 52 + $urandom_range(16);             // around the padding edge
        else if (r < 8)
            return $urandom_range(8);
        else
            return 64 * $urandom_range(2) + $urandom_range(63);
    endfunction

    int sent;
    int first_len;
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, byte extremes, finish with data ignored
        send_item(sha256t_pkg::CMD_FINISH, 8'hff);
        send_item(sha256t_pkg::CMD_ABSORB, 8'h00);
        send_item(sha256t_pkg::CMD_FINISH, 8'h00);
        send_item(sha256t_pkg::CMD_ABSORB, 8'hff);
        send_item(sha256t_pkg::CMD_ABSORB, 8'h55);
        send_item(sha256t_pkg::CMD_ABSORB, 8'haa);
        send_item(sha256t_pkg::CMD_FINISH, 8'h5a);
        send_item(sha256t_pkg::CMD_FINISH, 8'h00);
        // 55 bytes: padding fits in one block
        for (int i = 0; i < 55; i++)
            send_item(sha256t_pkg::CMD_ABSORB, 8'(i * 51));
        send_item(sha256t_pkg::CMD_FINISH, 8'h00);
        sent = 64;

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // boundary-length message (55, 56, 64 or 63 bytes) in each phase so the compression overlaps gaps
            first_len = (ph == 0) ? 55 : ((ph == 1) ? 56 : ((ph == 2) ? 64 : 63));
            send_message(first_len);
            sent += first_len + 1;
            while (sent < 64 + 140 * (ph + 1))
                begin
                    int n;
                    n = pick_len();
                    send_message(n);
                    sent += n + 1;
                end
        end
        // long message spanning several blocks
        send_message(200);
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
